// File: rtl/core/rbsi_pkg.sv
package rbsi_pkg;

   localparam int Q_W       = 32;            // q16.16 word
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = Q_W + 1 + FRAC_W; // scaled difference magnitude
   localparam int DIV_STEPS = NUM_W;          // one quotient bit per stage
   localparam int DIV_LAT   = DIV_STEPS + 2;  // setup + steps + saturation
   localparam int AXES      = 3;
   localparam int LANES     = 2 * AXES;

   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

   // per-axis flags that travel beside the dividers
   typedef struct packed {
      logic [AXES-1:0] dir_zero;
      logic [AXES-1:0] in_slab;
   } side_type;

endpackage

// File: rtl/core/rbsi_slab_div.sv
module rbsi_slab_div
   import rbsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [Q_W-1:0] corner,
   input  logic signed [Q_W-1:0] org,
   input  logic signed [Q_W-1:0] dir,
   output logic signed [Q_W-1:0] quot
);

   logic [Q_W-1:0]   rem_ff [0:DIV_STEPS];
   logic [NUM_W-1:0] nq_ff  [0:DIV_STEPS];
   logic [Q_W-1:0]   den_ff [0:DIV_STEPS];
   logic             neg_ff [0:DIV_STEPS];
   logic signed [Q_W-1:0] dist_ff;

   logic [Q_W:0]   diff;
   logic [Q_W:0]   diff_mag;
   logic [Q_W-1:0] dir_mag;
   logic [NUM_W-1:0] mag;
   logic             over;
   logic signed [Q_W-1:0] dist_in;

   assign diff     = {corner[Q_W-1], corner} - {org[Q_W-1], org};
   assign diff_mag = diff[Q_W] ? (~diff + 1'b1) : diff;
   assign dir_mag  = dir[Q_W-1] ? (~dir + 1'b1) : dir;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= {diff_mag, {FRAC_W{1'b0}}};
         den_ff[0] <= dir_mag;
         neg_ff[0] <= diff[Q_W] ^ dir[Q_W-1];
      end
   end

   // restoring division, one quotient bit shifted into nq per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [Q_W:0] trial;
      logic [Q_W:0] sub;
      logic         ge;
      assign trial = {rem_ff[k], nq_ff[k][NUM_W-1]};
      assign sub   = trial - {1'b0, den_ff[k]};
      assign ge    = trial >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? sub[Q_W-1:0] : trial[Q_W-1:0];
            nq_ff[k+1]  <= {nq_ff[k][NUM_W-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // saturate the signed quotient to q16.16
   assign mag = nq_ff[DIV_STEPS];
   always_comb begin
      if (neg_ff[DIV_STEPS]) begin
         over    = (|mag[NUM_W-1:Q_W]) | (mag[Q_W-1] & (|mag[Q_W-2:0]));
         dist_in = over ? Q_MIN : (~mag[Q_W-1:0] + 1'b1);
      end else begin
         over    = (|mag[NUM_W-1:Q_W]) | mag[Q_W-1];
         dist_in = over ? Q_MAX : mag[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   assign quot = dist_ff;

endmodule

// File: rtl/core/rbsi_merge.sv
module rbsi_merge
   import rbsi_pkg::*;
(
   input  side_type              side,
   input  logic signed [Q_W-1:0] quot [0:LANES-1],
   output logic                  hit,
   output logic signed [Q_W-1:0] t_near,
   output logic signed [Q_W-1:0] t_far
);

   always_comb begin
      logic                  done;
      logic signed [Q_W-1:0] lo;
      logic signed [Q_W-1:0] hi;
      hit    = 1'b1;
      done   = 1'b0;
      t_near = Q_MIN;
      t_far  = Q_MAX;
      for (int a = 0; a < AXES; a++) begin
         lo = (quot[2*a] < quot[2*a+1]) ? quot[2*a] : quot[2*a+1];
         hi = (quot[2*a] < quot[2*a+1]) ? quot[2*a+1] : quot[2*a];
         if (!done) begin
            if (side.dir_zero[a]) begin
               if (!side.in_slab[a]) begin
                  hit  = 1'b0;
                  done = 1'b1;
               end
            end else begin
               if (lo > t_near) t_near = lo;
               if (hi < t_far)  t_far  = hi;
               if (t_near > t_far) begin
                  hit  = 1'b0;
                  done = 1'b1;
               end
            end
         end
      end
   end

endmodule

// File: rtl/core/ray_box_slab_intersect.sv
// ray versus axis-aligned box, slab test, all values signed q16.16
//
// req channel: one word per ray/box pair, twelve 32-bit fields
// rsp channel: one word per request with hit flag, entry and exit distance
// a word moves when tvalid and tready are both high
//
// six divider lanes (min and max corner of each axis) run side by side,
// each a restoring divider with one quotient bit per stage; a merge stage
// then walks x, y, z in order and stops at the first empty slab
//
// a request passes the setup stage, 49 divider stages, the saturation stage
// and the output register on its way to rsp_tvalid
// throughput: one word per cycle while the receiver does not stall, set by the fully pipelined dividers
//
// reset (synchronous, active high) empties the pipeline; payload is not
// cleared. when the receiver stalls the whole pipeline freezes and
// req_tready drops, so no word is lost or repeated
module ray_box_slab_intersect
   import rbsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, t_near, t_far, zero pad
   output logic [71:0]  rsp_tdata
);

   logic en;
   logic signed [Q_W-1:0] fld [0:4*AXES-1];
   logic signed [Q_W-1:0] quot [0:LANES-1];

   logic     vld_ff  [0:DIV_LAT-1];
   side_type side_ff [0:DIV_LAT-1];
   side_type side_in;

   logic                  hit_c;
   logic signed [Q_W-1:0] near_c;
   logic signed [Q_W-1:0] far_c;

   logic                  rsp_tvalid_ff;
   logic                  hit_ff;
   logic signed [Q_W-1:0] near_ff;
   logic signed [Q_W-1:0] far_ff;

   // pipeline advances unless a finished word is held by the receiver
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   for (genvar i = 0; i < 4*AXES; i++) begin : g_fld
      assign fld[i] = req_tdata[Q_W*i +: Q_W];
   end

   // zero-direction axes are decided by a plain range check
   for (genvar a = 0; a < AXES; a++) begin : g_side
      assign side_in.dir_zero[a] = (fld[AXES+a] == '0);
      assign side_in.in_slab[a]  = (fld[a] >= fld[2*AXES+a]) && (fld[a] <= fld[3*AXES+a]);
      rbsi_slab_div u_div_min (
         .clock (clock),
         .en    (en),
         .corner(fld[2*AXES+a]),
         .org   (fld[a]),
         .dir   (fld[AXES+a]),
         .quot  (quot[2*a])
      );
      rbsi_slab_div u_div_max (
         .clock (clock),
         .en    (en),
         .corner(fld[3*AXES+a]),
         .org   (fld[a]),
         .dir   (fld[AXES+a]),
         .quot  (quot[2*a+1])
      );
   end

   // valid and flags travel beside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < DIV_LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   rbsi_merge u_merge (
      .side  (side_ff[DIV_LAT-1]),
      .quot  (quot),
      .hit   (hit_c),
      .t_near(near_c),
      .t_far (far_c)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= vld_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_c;
         near_ff <= near_c;
         far_ff  <= far_c;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, far_ff, near_ff, hit_ff};

   // a reported hit always has a non-empty interval
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit_ff |-> near_ff <= far_ff)
      else $error("hit with t_near above t_far");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // a word leaving the last stage reaches the output register
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[DIV_LAT-1] |=> rsp_tvalid)
      else $error("word lost between pipeline and output");

endmodule

// File: bench/ray_box_slab_intersect_test.sv
`timescale 1ns / 1ps

// slab-test ray/box checker: directed edge rays, then random rays in three idling phases
module ray_box_slab_intersect_test;
   import rbsi_pkg::*;

   typedef logic signed [31:0] q_type;

   typedef struct packed {
      logic  hit;
      q_type t_near;
      q_type t_far;
   } slab_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [383:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   // idle rates in percent, changed per phase
   int unsigned     send_idle_pct;
   int unsigned     recv_idle_pct;
   int unsigned     fail_count;
   slab_result_type expected_hits[$];

   localparam q_type QMIN = Q_MIN;
   localparam q_type QMAX = Q_MAX;
   localparam q_type ONE  = 32'sh0001_0000;

   ray_box_slab_intersect DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // one slab distance: exact scaled difference over dir, truncated, saturated
   function automatic longint slab_dist(q_type corner, q_type org, q_type dir);
      longint num;
      longint q;
      num = (longint'(corner) - longint'(org)) * 65536;
      q = num / longint'(dir);
      if (q > longint'(QMAX)) q = QMAX;
      if (q < longint'(QMIN)) q = QMIN;
      return q;
   endfunction

   // walks x, y, z and stops at the first empty slab
   function automatic slab_result_type ray_box_overlap(q_type f[12]);
      slab_result_type r;
      longint near_t;
      longint far_t;
      longint t1;
      longint t2;
      near_t = QMIN;
      far_t  = QMAX;
      r.hit  = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (f[3+a] == 0) begin
            if (f[a] < f[6+a] || f[a] > f[9+a]) begin
               r.hit = 1'b0;
               break;
            end
         end else begin
            t1 = slab_dist(f[6+a], f[a], f[3+a]);
            t2 = slab_dist(f[9+a], f[a], f[3+a]);
            if (t1 > t2) begin
               t1 = t1 ^ t2;
               t2 = t1 ^ t2;
               t1 = t1 ^ t2;
            end
            if (t1 > near_t) near_t = t1;
            if (t2 < far_t) far_t = t2;
            if (near_t > far_t) begin
               r.hit = 1'b0;
               break;
            end
         end
      end
      r.t_near = q_type'(near_t);
      r.t_far  = q_type'(far_t);
      return r;
   endfunction

   // sends one ray/box word, queueing its prediction on acceptance
   task automatic send_ray(q_type f[12]);
      logic [383:0] word;
      for (int i = 0; i < 12; i++) word[32*i +: 32] = f[i];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_hits.push_back(ray_box_overlap(f));
   endtask

   // receiver stalls at random; each accepted word is checked in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            slab_result_type got;
            slab_result_type want;
            got.hit    = rsp_tdata[0];
            got.t_near = rsp_tdata[32:1];
            got.t_far  = rsp_tdata[64:33];
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result hit=%0b near=%0d far=%0d",
                        $time, got.hit, got.t_near, got.t_far);
               fail_count++;
            end else begin
               want = expected_hits.pop_front();
               if (got.hit !== want.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                  fail_count++;
               end
               if (got.t_near !== want.t_near) begin
                  $display("%0t: t_near expected %0d actual %0d",
                           $time, want.t_near, got.t_near);
                  fail_count++;
               end
               if (got.t_far !== want.t_far) begin
                  $display("%0t: t_far expected %0d actual %0d",
                           $time, want.t_far, got.t_far);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic q_type rand_q();
      case ($urandom_range(5))
         0: return q_type'($urandom);
         1: return QMIN + q_type'($urandom_range(3));
         2: return QMAX - q_type'($urandom_range(3));
         3: return 0;
         default: return q_type'($urandom_range(40 * 65536)) - 20 * ONE;
      endcase
   endfunction

   // box around the origin region or fully random fields, direction sometimes zero or tiny
   task automatic send_random_ray();
      q_type f[12];
      q_type lo;
      q_type hi;
      if ($urandom_range(9) < 2) begin
         for (int i = 0; i < 12; i++) f[i] = rand_q();
      end else begin
         for (int a = 0; a < 3; a++) begin
            f[a] = q_type'($urandom_range(20 * 65536)) - 10 * ONE;
            case ($urandom_range(7))
               0: f[3+a] = 0;
               1: f[3+a] = q_type'($urandom_range(3)) - 1;
               2: f[3+a] = rand_q();
               default: f[3+a] = q_type'($urandom_range(4 * 65536)) - 2 * ONE;
            endcase
            lo = q_type'($urandom_range(20 * 65536)) - 10 * ONE;
            hi = lo + q_type'($urandom_range(8 * 65536));
            if ($urandom_range(15) == 0) begin
               f[6+a] = hi;
               f[9+a] = lo;
            end else begin
               f[6+a] = lo;
               f[9+a] = hi;
            end
         end
      end
      send_ray(f);
   endtask

   // extremes, zero directions, swapped corners, saturating quotients
   task automatic test_directed();
      q_type f[12];
      f = '{0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE};
      send_ray(f);
      // zero direction, origin within every slab
      f = '{0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE};
      send_ray(f);
      // zero direction, origin outside on y
      f = '{0, 5 * ONE, 0, ONE, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE};
      send_ray(f);
      // zero direction on the slab boundary
      f = '{ONE, -ONE, 0, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE};
      send_ray(f);
      // swapped corners, nonzero and zero direction
      f = '{0, 0, 0, ONE, -ONE, ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE};
      send_ray(f);
      f = '{0, 0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE};
      send_ray(f);
      // miss at y after tightening on x
      f = '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, -ONE, -ONE, 3 * ONE, ONE, ONE};
      send_ray(f);
      // miss at z with disjoint slabs
      f = '{0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, 5 * ONE, ONE, ONE, 6 * ONE};
      send_ray(f);
      // saturating quotients: tiny direction, extreme corners
      f = '{QMIN, QMAX, 0, 1, -1, 1, QMAX, QMIN, QMIN, QMAX, QMAX, QMAX};
      send_ray(f);
      f = '{QMAX, QMIN, QMAX, QMIN, QMAX, -1, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX};
      send_ray(f);
      f = '{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN};
      send_ray(f);
      f = '{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX};
      send_ray(f);
      f = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
      send_ray(f);
      // negative direction
      f = '{0, 0, 0, -ONE, -2 * ONE, -ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE};
      send_ray(f);
   endtask

   task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n) send_random_ray();
   endtask

   initial begin
      fail_count    = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 15, 83);
      test_random(300, 83, 15);
      test_random(300, 0, 0);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: ray_box_slab_intersect.f
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_slab_div.sv
rtl/core/rbsi_merge.sv
rtl/core/ray_box_slab_intersect.sv
bench/ray_box_slab_intersect_test.sv
